// ===== design/spectral_noise_subtract_defines.svh =====
// ----------------------------------------------------------------------------
// Spectral noise subtract assertion macros
// Shared concurrent-check shorthands, clocked on clk_i, reset on rst_ni.
// ----------------------------------------------------------------------------
`ifndef SPECTRAL_NOISE_SUBTRACT_DEFINES_SVH
`define SPECTRAL_NOISE_SUBTRACT_DEFINES_SVH

// Property that must hold on every clock edge out of reset.
`define SNR_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// Antecedent on one edge implies consequent on the next edge.
`define SNR_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== design/snr_pkg.sv =====
// ----------------------------------------------------------------------------
// snr_pkg
// Widths, pipeline tag type and helpers for the spectral noise subtractor.
// ----------------------------------------------------------------------------
package snr_pkg;

  localparam int unsigned FFT_POINTS = 512;
  localparam int unsigned NOISE_BINS = (FFT_POINTS / 2) + 1;
  localparam int unsigned ADDR_W     = $clog2(NOISE_BINS);
  localparam int unsigned POS_W      = $clog2(NOISE_BINS + 1);

  localparam int unsigned PWR_W      = 32;  // Q16.16 power
  localparam int unsigned CNT_W      = 16;  // frame counter / target
  localparam int unsigned STR_W      = 16;  // Q4.12 strength
  localparam int unsigned STR_FRAC   = 12;
  localparam int unsigned CFG_IDX_W  = 2;

  localparam int unsigned ACC_W      = PWR_W + CNT_W;      // mean * count + power
  localparam int unsigned DIV_W      = CNT_W + 1;          // count + 1
  localparam int unsigned QUO_W      = PWR_W;
  localparam int unsigned DIV_BPS    = 2;                  // quotient bits per stage
  localparam int unsigned DIV_STAGES = QUO_W / DIV_BPS;
  localparam int unsigned PROD_W     = PWR_W + STR_W - STR_FRAC;

  // Register indexes on the config port.
  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_ENABLE,
    CFG_TARGET,
    CFG_STRENGTH,
    CFG_FLOOR
  } cfg_idx_e;

  // Per-item control and payload carried down the pipe.
  typedef struct packed {
    logic              valid;
    logic [ADDR_W-1:0] addr;
    logic              we;     // noise entry is rewritten
    logic              sub;    // subtraction applies
    logic              last;
    logic [PWR_W-1:0]  power;
  } tag_t;

  // True when an in-flight item will write the given noise entry.
  function automatic logic tag_hit(input tag_t t, input logic [ADDR_W-1:0] a);
    tag_hit = t.valid && t.we && (t.addr == a);
  endfunction

endpackage

// ===== design/spectral_noise_subtract.sv =====
// ----------------------------------------------------------------------------
// spectral_noise_subtract
// Per-bin noise mean learning and spectral subtraction on a bin stream.
// ----------------------------------------------------------------------------
// Pipeline: read, multiply, add, 16 divider stages, strength multiply and
//   output register lie between item acceptance and out_valid_o.
// Throughput: one item per cycle while the output is not stalled; a bin whose
//   noise entry is still in the 19-deep update pipe (learning frames of 19
//   bins or fewer) waits until it is written back.
// Reset: a pass zeroes all 257 noise RAM entries; in_ready_o stays low
//   meanwhile, config writes are taken. Config regs reset to 0, 10, 4096 and 1.
// ----------------------------------------------------------------------------
`include "spectral_noise_subtract_defines.svh"

module spectral_noise_subtract (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  // config write port
  input  logic                          cfg_we_i,
  input  logic [snr_pkg::CFG_IDX_W-1:0] cfg_idx_i,
  input  logic [snr_pkg::PWR_W-1:0]     cfg_data_i,
  // bin input
  input  logic                          in_valid_i,
  output logic                          in_ready_o,
  input  logic [snr_pkg::PWR_W-1:0]     power_in_i,
  input  logic                          frame_end_i,
  // cleaned bin output
  output logic                          out_valid_o,
  input  logic                          out_ready_i,
  output logic [snr_pkg::PWR_W-1:0]     power_out_o,
  output logic                          frame_end_out_o,
  output logic                          subtracted_o
);
  import snr_pkg::*;

  // Config registers
  logic             en_q;
  logic [CNT_W-1:0] target_q;
  logic [STR_W-1:0] strength_q;
  logic [PWR_W-1:0] floor_q;

  // Stream state: learned frame count and bin position in the frame
  logic [CNT_W-1:0] fl_q;
  logic [POS_W-1:0] pos_q;

  // RAM clear pass after reset
  logic              clr_q;
  logic [ADDR_W-1:0] clr_cnt_q;

  // Global pipe advance: every stage moves when the output register frees
  logic adv;
  logic acc_in;
  logic hit_front;
  logic hit_div;

  // Decisions made on the accepted bin
  logic              in_range;
  logic              learning;
  logic [DIV_W-1:0]  eff_cnt;
  logic              do_sub;
  logic [ADDR_W-1:0] probe_addr;
  tag_t              tag_acc;

  // Front pipe: s1 (RAM read data), s2 (mean * count), s3 (+ power)
  tag_t             tag_s1_q, tag_s2_q, tag_s3_q;
  logic             learn_s1_q, learn_s2_q;
  logic [CNT_W-1:0] fac_s1_q;
  logic [DIV_W-1:0] dvs_s1_q, dvs_s2_q, dvs_s3_q;
  logic [ACC_W-1:0] prod_s2_q, acc_s3_q;
  logic [PWR_W-1:0] rd_data;

  // Divider output and RAM write port
  tag_t              div_tag;
  logic [QUO_W-1:0]  div_quot;
  logic              pipe_we;
  logic              ram_we;
  logic [ADDR_W-1:0] ram_waddr;
  logic [PWR_W-1:0]  ram_wdata;

  // ---------------------------------------------------------------------------
  // Input side: learn/subtract decision from the state as it stands now.
  // A learning bin of the frame that reaches the target already subtracts.
  // ---------------------------------------------------------------------------
  assign in_range   = pos_q < POS_W'(NOISE_BINS);
  assign learning   = en_q && (fl_q < target_q);
  assign eff_cnt    = DIV_W'(fl_q) + DIV_W'(learning);
  assign do_sub     = in_range && en_q && (eff_cnt >= DIV_W'(target_q));
  assign probe_addr = pos_q[ADDR_W-1:0];

  assign adv        = !out_valid_o || out_ready_i;
  // Interlock: never read an entry whose update has not landed in the RAM.
  assign in_ready_o = adv && !clr_q && !hit_front && !hit_div;
  assign acc_in     = in_valid_i && in_ready_o;

  always_comb begin
    tag_acc       = '0;
    tag_acc.valid = acc_in;
    tag_acc.addr  = probe_addr;
    tag_acc.we    = in_range && learning;
    tag_acc.sub   = do_sub;
    tag_acc.last  = frame_end_i;
    tag_acc.power = power_in_i;
  end

  assign hit_front = tag_hit(tag_s1_q, probe_addr) || tag_hit(tag_s2_q, probe_addr) ||
                     tag_hit(tag_s3_q, probe_addr);

  // ---------------------------------------------------------------------------
  // Config and stream state
  // ---------------------------------------------------------------------------
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      en_q       <= 1'b0;
      target_q   <= CNT_W'(10);
      strength_q <= STR_W'(4096);
      floor_q    <= PWR_W'(1);
      fl_q       <= '0;
      pos_q      <= '0;
      clr_q      <= 1'b1;
      clr_cnt_q  <= '0;
    end else begin
      if (cfg_we_i) begin
        unique case (cfg_idx_e'(cfg_idx_i))
          CFG_ENABLE:   en_q       <= cfg_data_i[0];
          CFG_TARGET:   target_q   <= cfg_data_i[CNT_W-1:0];
          CFG_STRENGTH: strength_q <= cfg_data_i[STR_W-1:0];
          CFG_FLOOR:    floor_q    <= cfg_data_i;
        endcase
      end
      if (acc_in) begin
        if (frame_end_i) begin
          if (learning) begin
            fl_q <= fl_q + CNT_W'(1);
          end
          pos_q <= '0;
        end else if (in_range) begin
          pos_q <= pos_q + POS_W'(1);
        end
      end
      if (clr_q) begin
        clr_cnt_q <= clr_cnt_q + ADDR_W'(1);
        if (clr_cnt_q == ADDR_W'(NOISE_BINS - 1)) begin
          clr_q <= 1'b0;
        end
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Front pipe. Non-learning bins go through as mean * 1 / 1 so the divider
  // hands back the stored mean unchanged.
  // ---------------------------------------------------------------------------
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tag_s1_q <= '0;
      tag_s2_q <= '0;
      tag_s3_q <= '0;
    end else if (adv) begin
      tag_s1_q <= tag_acc;
      tag_s2_q <= tag_s1_q;
      tag_s3_q <= tag_s2_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      learn_s1_q <= learning;
      fac_s1_q   <= learning ? fl_q : CNT_W'(1);
      dvs_s1_q   <= learning ? (DIV_W'(fl_q) + DIV_W'(1)) : DIV_W'(1);
      learn_s2_q <= learn_s1_q;
      dvs_s2_q   <= dvs_s1_q;
      prod_s2_q  <= ACC_W'(rd_data) * ACC_W'(fac_s1_q);
      dvs_s3_q   <= dvs_s2_q;
      acc_s3_q   <= prod_s2_q + (learn_s2_q ? ACC_W'(tag_s2_q.power) : ACC_W'(0));
    end
  end

  // ---------------------------------------------------------------------------
  // Noise RAM: cleared after reset, then written back by the divider output
  // ---------------------------------------------------------------------------
  assign pipe_we   = adv && div_tag.valid && div_tag.we;
  assign ram_we    = clr_q || pipe_we;
  assign ram_waddr = clr_q ? clr_cnt_q : div_tag.addr;
  assign ram_wdata = clr_q ? PWR_W'(0) : div_quot;

  snr_ram #(
    .DEPTH (NOISE_BINS),
    .DW    (PWR_W),
    .AW    (ADDR_W)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .re_i    (acc_in && in_range),
    .raddr_i (probe_addr),
    .rdata_o (rd_data)
  );

  snr_div u_div (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .adv_i        (adv),
    .tag_i        (tag_s3_q),
    .dividend_i   (acc_s3_q),
    .divisor_i    (dvs_s3_q),
    .probe_addr_i (probe_addr),
    .hit_o        (hit_div),
    .tag_o        (div_tag),
    .quot_o       (div_quot)
  );

  // Subtraction uses the mean just computed, matching the updated store.
  snr_sub u_sub (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .adv_i       (adv),
    .tag_i       (div_tag),
    .mean_i      (div_quot),
    .strength_i  (strength_q),
    .floor_i     (floor_q),
    .out_valid_o (out_valid_o),
    .power_o     (power_out_o),
    .last_o      (frame_end_out_o),
    .sub_o       (subtracted_o)
  );

  // ---------------------------------------------------------------------------
  // Assertions
  // ---------------------------------------------------------------------------
  `SNR_ASSERT(a_no_wb_in_clear, !(clr_q && pipe_we), "write-back during RAM clear")
  `SNR_ASSERT(a_pos_bound, pos_q <= POS_W'(NOISE_BINS), "bin position past saturation")
  `SNR_ASSERT_NEXT(a_fl_hold, !(acc_in && frame_end_i), $stable(fl_q), "frame count moved")
  `SNR_ASSERT(a_sub_needs_en, !(out_valid_o && subtracted_o) || en_q, "subtracted, disabled")

endmodule

// ===== design/snr_ram.sv =====
// ----------------------------------------------------------------------------
// snr_ram
// Simple dual-port RAM, one write and one read port, registered read data.
// ----------------------------------------------------------------------------
module snr_ram #(
  parameter int unsigned DEPTH = 257,
  parameter int unsigned DW    = 32,
  parameter int unsigned AW    = $clog2(DEPTH)
) (
  input  logic          clk_i,
  input  logic          we_i,
  input  logic [AW-1:0] waddr_i,
  input  logic [DW-1:0] wdata_i,
  input  logic          re_i,
  input  logic [AW-1:0] raddr_i,
  output logic [DW-1:0] rdata_o
);

  logic [DW-1:0] mem [DEPTH];
  logic [DW-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ===== design/snr_div.sv =====
// ----------------------------------------------------------------------------
// snr_div
// Pipelined restoring divider, two quotient bits per stage, with tag.
// ----------------------------------------------------------------------------
module snr_div (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         adv_i,
  input  snr_pkg::tag_t                tag_i,
  input  logic [snr_pkg::ACC_W-1:0]    dividend_i,
  input  logic [snr_pkg::DIV_W-1:0]    divisor_i,
  input  logic [snr_pkg::ADDR_W-1:0]   probe_addr_i,
  output logic                         hit_o,
  output snr_pkg::tag_t                tag_o,
  output logic [snr_pkg::QUO_W-1:0]    quot_o
);
  import snr_pkg::*;

  tag_t             tag_q  [DIV_STAGES];
  tag_t             tag_in [DIV_STAGES];
  logic [DIV_W-1:0] rem_q  [DIV_STAGES];
  logic [DIV_W-1:0] rem_in [DIV_STAGES];
  logic [DIV_W-1:0] rem_d  [DIV_STAGES];
  logic [DIV_W-1:0] dvs_q  [DIV_STAGES];
  logic [DIV_W-1:0] dvs_in [DIV_STAGES];
  logic [QUO_W-1:0] lo_q   [DIV_STAGES];
  logic [QUO_W-1:0] lo_in  [DIV_STAGES];
  logic [QUO_W-1:0] lo_d   [DIV_STAGES];

  // One restoring step: lo holds unused dividend bits on top, quotient below.
  function automatic logic [DIV_W+QUO_W-1:0] div_bit(input logic [DIV_W-1:0] rem,
                                                     input logic [QUO_W-1:0] lo,
                                                     input logic [DIV_W-1:0] dv);
    logic [DIV_W:0] trial;
    logic [DIV_W:0] diff;
    trial = {rem, lo[QUO_W-1]};
    diff  = trial - {1'b0, dv};
    if (trial >= {1'b0, dv}) begin
      div_bit = {diff[DIV_W-1:0], lo[QUO_W-2:0], 1'b1};
    end else begin
      div_bit = {trial[DIV_W-1:0], lo[QUO_W-2:0], 1'b0};
    end
  endfunction

  // Quotient fits QUO_W bits, so the top dividend bits start below the divisor.
  assign tag_in[0] = tag_i;
  assign rem_in[0] = DIV_W'(dividend_i[ACC_W-1:QUO_W]);
  assign lo_in[0]  = dividend_i[QUO_W-1:0];
  assign dvs_in[0] = divisor_i;

  for (genvar s = 1; s < DIV_STAGES; s++) begin : g_link
    assign tag_in[s] = tag_q[s-1];
    assign rem_in[s] = rem_q[s-1];
    assign lo_in[s]  = lo_q[s-1];
    assign dvs_in[s] = dvs_q[s-1];
  end

  always_comb begin
    for (int s = 0; s < DIV_STAGES; s++) begin
      rem_d[s] = rem_in[s];
      lo_d[s]  = lo_in[s];
      for (int b = 0; b < DIV_BPS; b++) begin
        {rem_d[s], lo_d[s]} = div_bit(rem_d[s], lo_d[s], dvs_in[s]);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int s = 0; s < DIV_STAGES; s++) begin
        tag_q[s] <= '0;
      end
    end else if (adv_i) begin
      for (int s = 0; s < DIV_STAGES; s++) begin
        tag_q[s] <= tag_in[s];
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv_i) begin
      for (int s = 0; s < DIV_STAGES; s++) begin
        rem_q[s] <= rem_d[s];
        lo_q[s]  <= lo_d[s];
        dvs_q[s] <= dvs_in[s];
      end
    end
  end

  always_comb begin
    hit_o = 1'b0;
    for (int s = 0; s < DIV_STAGES; s++) begin
      if (tag_hit(tag_q[s], probe_addr_i)) begin
        hit_o = 1'b1;
      end
    end
  end

  assign tag_o  = tag_q[DIV_STAGES-1];
  assign quot_o = lo_q[DIV_STAGES-1];

endmodule

// ===== design/snr_sub.sv =====
// ----------------------------------------------------------------------------
// snr_sub
// Strength-weighted noise subtraction with floor, and the output register.
// ----------------------------------------------------------------------------
module snr_sub (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       adv_i,
  input  snr_pkg::tag_t              tag_i,
  input  logic [snr_pkg::PWR_W-1:0]  mean_i,
  input  logic [snr_pkg::STR_W-1:0]  strength_i,
  input  logic [snr_pkg::PWR_W-1:0]  floor_i,
  output logic                       out_valid_o,
  output logic [snr_pkg::PWR_W-1:0]  power_o,
  output logic                       last_o,
  output logic                       sub_o
);
  import snr_pkg::*;

  localparam int unsigned FULL_W = PWR_W + STR_W;

  tag_t              tag_m_q;
  logic [PROD_W-1:0] prod_m_q;
  logic [FULL_W-1:0] prod_full;
  logic [PWR_W-1:0]  diff;
  logic [PWR_W-1:0]  result;
  logic              out_valid_q;
  logic [PWR_W-1:0]  power_q;
  logic              last_q;
  logic              sub_q;

  assign prod_full = FULL_W'(strength_i) * FULL_W'(mean_i);
  assign diff      = tag_m_q.power - prod_m_q[PWR_W-1:0];

  always_comb begin
    result = tag_m_q.power;
    if (tag_m_q.sub) begin
      if (prod_m_q >= PROD_W'(tag_m_q.power)) begin
        result = floor_i;
      end else if (diff < floor_i) begin
        result = floor_i;
      end else begin
        result = diff;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tag_m_q     <= '0;
      out_valid_q <= 1'b0;
    end else if (adv_i) begin
      tag_m_q     <= tag_i;
      out_valid_q <= tag_m_q.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv_i) begin
      prod_m_q <= prod_full[FULL_W-1:STR_FRAC];
      power_q  <= result;
      last_q   <= tag_m_q.last;
      sub_q    <= tag_m_q.sub;
    end
  end

  assign out_valid_o = out_valid_q;
  assign power_o     = power_q;
  assign last_o      = last_q;
  assign sub_o       = sub_q;

endmodule

// ===== bench/spectral_noise_subtract_test.sv =====
// ----------------------------------------------------------------------------
// spectral_noise_subtract_test
// Self-checking bench for the spectral noise subtractor. A table of directed
// bins and register writes runs first, then random config phases each send a
// stream of frames with random bursts. Every accepted bin is predicted by an
// in-bench model of the noise learning and subtraction, and every result is
// compared in order. The receiver stalls on its own pattern, with one long
// hold-off that backs the block up into its input.
// ----------------------------------------------------------------------------
module spectral_noise_subtract_test;
  timeunit 1ns;
  timeprecision 1ps;

  import snr_pkg::*;

  localparam int RANDOM_BINS  = 1500;
  localparam int PIPE_LATENCY = 20;       // sets the final drain wait
  localparam int HOLD_CYCLES  = 300;      // long receiver hold-off
  localparam int CYCLE_LIMIT  = 1000000;
  localparam int REPORT_MAX   = 10;

  typedef enum logic {ROW_BIN, ROW_CFG} row_kind_e;

  // Receiver ready patterns.
  typedef enum logic [1:0] {STALL_NONE, STALL_LIGHT, STALL_PATTERN, STALL_HEAVY} stall_e;

  typedef struct packed {
    logic [PWR_W-1:0] power;
    logic             last;
    logic             sub;
  } bin_result_t;

  // One directed step: a bin (optionally with its result pinned) or a write.
  typedef struct packed {
    row_kind_e        kind;
    cfg_idx_e         sel;
    logic [PWR_W-1:0] value;
    logic             last;
    logic             pinned;
    logic [PWR_W-1:0] pin_power;
    logic             pin_sub;
  } row_t;

  // DUT ports
  logic                clk_i;
  logic                rst_ni      = 1'b0;
  logic                cfg_we_i    = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_idx_i  = '0;
  logic [PWR_W-1:0]    cfg_data_i  = '0;
  logic                in_valid_i  = 1'b0;
  logic                in_ready_o;
  logic [PWR_W-1:0]    power_in_i  = '0;
  logic                frame_end_i = 1'b0;
  logic                out_valid_o;
  logic                out_ready_i = 1'b0;
  logic [PWR_W-1:0]    power_out_o;
  logic                frame_end_out_o;
  logic                subtracted_o;

  // Mirror of the block: config registers and learned noise.
  logic             enable_q   = 1'b0;
  logic [CNT_W-1:0] target_q   = 16'd10;
  logic [STR_W-1:0] strength_q = 16'd4096;
  logic [PWR_W-1:0] floor_q    = 32'd1;
  logic [PWR_W-1:0] noise_mean [NOISE_BINS];
  logic [CNT_W-1:0] frames_done = '0;
  int unsigned      bin_pos     = 0;

  bin_result_t cleaned_due[$];   // predicted results, oldest first
  row_t        bench_rows[$];

  int bins_sent, frames_sent, long_frames, phases_run;
  int results_seen, results_subtracted, bad_bins;
  int cycle_count;
  logic hold_req = 1'b0;

  spectral_noise_subtract dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cfg_we_i       (cfg_we_i),
    .cfg_idx_i      (cfg_idx_i),
    .cfg_data_i     (cfg_data_i),
    .in_valid_i     (in_valid_i),
    .in_ready_o     (in_ready_o),
    .power_in_i     (power_in_i),
    .frame_end_i    (frame_end_i),
    .out_valid_o    (out_valid_o),
    .out_ready_i    (out_ready_i),
    .power_out_o    (power_out_o),
    .frame_end_out_o(frame_end_out_o),
    .subtracted_o   (subtracted_o)
  );

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  // Predict one bin and advance the mirror. Learning updates the running
  // mean first, so the frame that reaches the target is already subtracted
  // with its own contribution folded in.
  function automatic bin_result_t clean_bin(input logic [PWR_W-1:0] pwr, input logic last);
    bin_result_t      res;
    logic             learning;
    logic [CNT_W:0]   eff;
    logic             in_range;
    logic [63:0]      acc;
    logic [63:0]      prod;
    logic [PWR_W-1:0] diff;
    res      = '{power: pwr, last: last, sub: 1'b0};
    learning = enable_q && (frames_done < target_q);
    eff      = {1'b0, frames_done} + learning;
    in_range = bin_pos < NOISE_BINS;
    if (in_range && learning) begin
      acc = 64'(noise_mean[bin_pos]) * 64'(frames_done) + 64'(pwr);
      noise_mean[bin_pos] = PWR_W'(acc / (64'(frames_done) + 64'd1));
    end
    if (in_range && enable_q && eff >= {1'b0, target_q}) begin
      prod = (64'(strength_q) * 64'(noise_mean[bin_pos])) >> STR_FRAC;
      if (prod >= 64'(pwr)) begin
        res.power = floor_q;
      end else begin
        diff      = pwr - PWR_W'(prod);
        res.power = (diff < floor_q) ? floor_q : diff;
      end
      res.sub = 1'b1;
    end
    if (last) begin
      if (learning) frames_done = frames_done + 1'b1;
      bin_pos = 0;
    end else if (bin_pos < NOISE_BINS) begin
      bin_pos++;
    end
    return res;
  endfunction

  function automatic row_t row(input row_kind_e kind, input cfg_idx_e sel,
                               input logic [PWR_W-1:0] value, input logic last,
                               input logic pinned, input logic [PWR_W-1:0] pin_power,
                               input logic pin_sub);
    row_t r;
    r.kind      = kind;
    r.sel       = sel;
    r.value     = value;
    r.last      = last;
    r.pinned    = pinned;
    r.pin_power = pin_power;
    r.pin_sub   = pin_sub;
    return r;
  endfunction

  // Offer one bin, hold it until taken, then queue its expected result.
  task automatic send_bin(input logic [PWR_W-1:0] pwr, input logic last,
                          input logic pinned, input bin_result_t pinned_res);
    bin_result_t res;
    in_valid_i  <= 1'b1;
    power_in_i  <= pwr;
    frame_end_i <= last;
    @(posedge clk_i);
    while (!in_ready_o) @(posedge clk_i);
    res = clean_bin(pwr, last);
    cleaned_due.push_back(pinned ? pinned_res : res);
    bins_sent++;
    if (last) frames_sent++;
  endtask

  // One register write; cfg_we_i drops again before return, so writes never overlap.
  task automatic write_reg(input cfg_idx_e sel, input logic [PWR_W-1:0] val);
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= sel;
    cfg_data_i <= val;
    @(posedge clk_i);
    case (sel)
      CFG_ENABLE:   enable_q   = val[0];
      CFG_TARGET:   target_q   = val[CNT_W-1:0];
      CFG_STRENGTH: strength_q = val[STR_W-1:0];
      CFG_FLOOR:    floor_q    = val;
      default: ;
    endcase
    cfg_we_i <= 1'b0;
    @(posedge clk_i);
  endtask

  // Stop offering and let every pending bin come out.
  task automatic wait_idle();
    in_valid_i <= 1'b0;
    while (cleaned_due.size() != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  // ---------------------------------------------------------------------------
  // Stimulus: directed table, then random config phases.
  // ---------------------------------------------------------------------------
  initial begin : stimulus
    bin_result_t      pin;
    logic             quiet;
    int               phase, phase_len, gap, burst_left, frame_left, pick, tgt;
    logic             steady;
    logic [PWR_W-1:0] pwr;
    logic [PWR_W-1:0] pmask;
    logic [PWR_W-1:0] val;

    foreach (noise_mean[i]) noise_mean[i] = '0;
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;

    // Out of reset the block passes bins through untouched.
    bench_rows.push_back(row(ROW_BIN, CFG_ENABLE, 32'h0, 1'b0, 1'b1, 32'h0, 1'b0));
    bench_rows.push_back(row(ROW_BIN, CFG_ENABLE, '1, 1'b1, 1'b1, '1, 1'b0));
    // Zero target: nothing learned, noise is zero, so a zero bin hits the floor
    // and a full-scale bin comes out as is.
    bench_rows.push_back(row(ROW_CFG, CFG_ENABLE, 32'd1, 1'b0, 1'b0, '0, 1'b0));
    bench_rows.push_back(row(ROW_CFG, CFG_TARGET, 32'd0, 1'b0, 1'b0, '0, 1'b0));
    bench_rows.push_back(row(ROW_BIN, CFG_ENABLE, 32'h0, 1'b0, 1'b1, 32'd1, 1'b1));
    bench_rows.push_back(row(ROW_BIN, CFG_ENABLE, '1, 1'b1, 1'b1, '1, 1'b1));
    // Target two: first frame learns and passes through.
    bench_rows.push_back(row(ROW_CFG, CFG_TARGET, 32'd2, 1'b0, 1'b0, '0, 1'b0));
    bench_rows.push_back(row(ROW_BIN, CFG_ENABLE, 32'h0010_0000, 1'b0, 1'b1, 32'h0010_0000, 1'b0));
    bench_rows.push_back(row(ROW_BIN, CFG_ENABLE, '1, 1'b0, 1'b1, '1, 1'b0));
    bench_rows.push_back(row(ROW_BIN, CFG_ENABLE, 32'h0000_8000, 1'b1, 1'b1, 32'h0000_8000, 1'b0));
    // Second frame reaches the target and is subtracted with its own mean.
    bench_rows.push_back(row(ROW_BIN, CFG_ENABLE, 32'h0030_0000, 1'b0, 1'b0, '0, 1'b0));
    bench_rows.push_back(row(ROW_BIN, CFG_ENABLE, 32'h0, 1'b0, 1'b0, '0, 1'b0));
    bench_rows.push_back(row(ROW_BIN, CFG_ENABLE, 32'h0001_0000, 1'b1, 1'b0, '0, 1'b0));
    // Subtraction only.
    bench_rows.push_back(row(ROW_BIN, CFG_ENABLE, 32'h0040_0000, 1'b0, 1'b0, '0, 1'b0));
    bench_rows.push_back(row(ROW_BIN, CFG_ENABLE, 32'h7FFF_FFFF, 1'b0, 1'b0, '0, 1'b0));
    bench_rows.push_back(row(ROW_BIN, CFG_ENABLE, 32'h0000_FFFF, 1'b1, 1'b0, '0, 1'b0));
    // Strongest weight, zero floor.
    bench_rows.push_back(row(ROW_CFG, CFG_STRENGTH, 32'hFFFF, 1'b0, 1'b0, '0, 1'b0));
    bench_rows.push_back(row(ROW_CFG, CFG_FLOOR, 32'h0, 1'b0, 1'b0, '0, 1'b0));
    bench_rows.push_back(row(ROW_BIN, CFG_ENABLE, '1, 1'b0, 1'b0, '0, 1'b0));
    bench_rows.push_back(row(ROW_BIN, CFG_ENABLE, 32'h0100_0000, 1'b0, 1'b0, '0, 1'b0));
    bench_rows.push_back(row(ROW_BIN, CFG_ENABLE, 32'h0, 1'b1, 1'b1, 32'h0, 1'b1));
    // Zero weight, full-scale floor: every subtracted bin sits on the floor.
    bench_rows.push_back(row(ROW_CFG, CFG_STRENGTH, 32'h0, 1'b0, 1'b0, '0, 1'b0));
    bench_rows.push_back(row(ROW_CFG, CFG_FLOOR, '1, 1'b0, 1'b0, '0, 1'b0));
    bench_rows.push_back(row(ROW_BIN, CFG_ENABLE, 32'h1234_5678, 1'b1, 1'b1, '1, 1'b1));
    // Target lowered below the learned count, then enable dropped mid-frame.
    bench_rows.push_back(row(ROW_CFG, CFG_STRENGTH, 32'd4096, 1'b0, 1'b0, '0, 1'b0));
    bench_rows.push_back(row(ROW_CFG, CFG_FLOOR, 32'd1, 1'b0, 1'b0, '0, 1'b0));
    bench_rows.push_back(row(ROW_CFG, CFG_TARGET, 32'd1, 1'b0, 1'b0, '0, 1'b0));
    bench_rows.push_back(row(ROW_BIN, CFG_ENABLE, 32'h0050_0000, 1'b0, 1'b0, '0, 1'b0));
    bench_rows.push_back(row(ROW_CFG, CFG_ENABLE, 32'd0, 1'b0, 1'b0, '0, 1'b0));
    bench_rows.push_back(row(ROW_BIN, CFG_ENABLE, 32'h0050_0000, 1'b0, 1'b1, 32'h0050_0000, 1'b0));
    bench_rows.push_back(row(ROW_CFG, CFG_ENABLE, 32'd1, 1'b0, 1'b0, '0, 1'b0));
    bench_rows.push_back(row(ROW_BIN, CFG_ENABLE, 32'h0050_0000, 1'b1, 1'b0, '0, 1'b0));
    // Target raised again: learning resumes on top of the stored mean.
    bench_rows.push_back(row(ROW_CFG, CFG_TARGET, 32'd4, 1'b0, 1'b0, '0, 1'b0));
    bench_rows.push_back(row(ROW_BIN, CFG_ENABLE, 32'hABCD_0000, 1'b0, 1'b0, '0, 1'b0));
    bench_rows.push_back(row(ROW_BIN, CFG_ENABLE, 32'h0000_1111, 1'b1, 1'b0, '0, 1'b0));

    quiet = 1'b0;
    foreach (bench_rows[i]) begin
      if (bench_rows[i].kind == ROW_CFG) begin
        if (!quiet) begin
          wait_idle();
          quiet = 1'b1;
        end
        write_reg(bench_rows[i].sel, bench_rows[i].value);
      end else begin
        quiet = 1'b0;
        pin = '{power: bench_rows[i].pin_power, last: bench_rows[i].last,
                sub: bench_rows[i].pin_sub};
        send_bin(bench_rows[i].value, bench_rows[i].last, bench_rows[i].pinned, pin);
      end
    end

    // Random phases. Frames run across phase edges, so config can change
    // mid-frame; the position counter carries over.
    frame_left = 0;
    burst_left = 0;
    for (phase = 0; bins_sent < bench_rows.size() + RANDOM_BINS; phase++) begin
      wait_idle();
      phases_run++;

      write_reg(CFG_ENABLE, 32'($urandom_range(0, 4) != 0));

      pick = $urandom_range(0, 99);
      if (pick < 10)      tgt = 0;
      else if (pick < 15) tgt = 65535;
      else if (pick < 75) tgt = int'(frames_done) + $urandom_range(0, 3);
      else                tgt = $urandom_range(0, 20);
      if (tgt > 65535) tgt = 65535;
      write_reg(CFG_TARGET, 32'(tgt));

      pick = $urandom_range(0, 99);
      if (pick < 5)       val = 32'h0;
      else if (pick < 10) val = 32'hFFFF;
      else if (pick < 30) val = 32'd4096;
      else if (pick < 70) val = $urandom_range(0, 8191);
      else                val = $urandom_range(0, 65535);
      write_reg(CFG_STRENGTH, val);

      pick = $urandom_range(0, 99);
      if (pick < 10)      val = 32'h0;
      else if (pick < 30) val = 32'd1;
      else if (pick < 33) val = '1;
      else if (pick < 73) val = $urandom_range(0, 65535);
      else                val = $urandom;
      write_reg(CFG_FLOOR, val);

      case ($urandom_range(0, 2))
        0:       pmask = '1;
        1:       pmask = 32'h00FF_FFFF;
        default: pmask = 32'h000F_FFFF;
      endcase
      if (phase == 0) pmask = '1;

      // Phase one streams flat out while the receiver holds off.
      steady    = (phase == 1) || ($urandom_range(0, 4) == 0);
      phase_len = (phase == 1) ? 400 : $urandom_range(60, 220);
      if (phase == 1) hold_req <= 1'b1;

      repeat (phase_len) begin
        if (frame_left == 0) begin
          pick = $urandom_range(0, 99);
          if (pick < 4)       frame_left = NOISE_BINS;
          else if (pick < 7)  frame_left = NOISE_BINS + $urandom_range(1, 5);
          else if (pick < 40) frame_left = $urandom_range(1, 18);
          else                frame_left = $urandom_range(19, 64);
          if (frame_left > NOISE_BINS) long_frames++;
        end
        if (burst_left == 0) begin
          if (!steady) begin
            gap = ($urandom_range(0, 9) == 0) ? $urandom_range(10, 30) : $urandom_range(1, 6);
            in_valid_i <= 1'b0;
            repeat (gap) @(posedge clk_i);
          end
          burst_left = $urandom_range(1, 24);
        end
        pick = $urandom_range(0, 99);
        if (pick < 3)      pwr = '0;
        else if (pick < 6) pwr = '1;
        else               pwr = $urandom & pmask;
        send_bin(pwr, frame_left == 1, 1'b0, '0);
        frame_left--;
        burst_left--;
      end
    end

    wait_idle();
    repeat (2 * PIPE_LATENCY) @(posedge clk_i);
    bad_bins += cleaned_due.size();

    $display("Ran %0d bins in %0d frames (%0d past the last bin), %0d random config phases",
             bins_sent, frames_sent, long_frames, phases_run);
    $display("Checked %0d results, %0d of them subtracted, %0d mismatches",
             results_seen, results_subtracted, bad_bins);
    if (bad_bins == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

  // ---------------------------------------------------------------------------
  // Receiver: ready follows a random stall mode, picked anew when its run ends.
  // Once the long hold-off is requested, ready is held low through the
  // HOLD_CYCLES hold-off so the pipe fills and in_ready_o drops.
  // ---------------------------------------------------------------------------
  initial begin : receiver
    stall_e      mode;
    int          mode_left;
    int unsigned tick;
    logic        held;
    mode      = STALL_NONE;
    mode_left = 0;
    tick      = 0;
    held      = 1'b0;
    forever begin
      @(posedge clk_i);
      if (hold_req && !held) begin
        held = 1'b1;
        out_ready_i <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk_i);
      end else begin
        if (mode_left == 0) begin
          mode      = stall_e'($urandom_range(0, 3));
          mode_left = $urandom_range(16, 96);
        end
        mode_left--;
        tick++;
        case (mode)
          STALL_NONE:    out_ready_i <= 1'b1;
          STALL_LIGHT:   out_ready_i <= ($urandom_range(0, 3) != 0);
          STALL_PATTERN: out_ready_i <= (tick % 3 != 0);
          default:       out_ready_i <= ($urandom_range(0, 3) == 0);
        endcase
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Result check: in order against the oldest prediction.
  // ---------------------------------------------------------------------------
  always @(posedge clk_i) begin : result_check
    bin_result_t want;
    if (rst_ni && out_valid_o && out_ready_i) begin
      results_seen++;
      if (cleaned_due.size() == 0) begin
        bad_bins++;
        if (bad_bins <= REPORT_MAX)
          $display("unexpected result: power %h last %b sub %b",
                   power_out_o, frame_end_out_o, subtracted_o);
      end else begin
        want = cleaned_due.pop_front();
        if (power_out_o !== want.power || frame_end_out_o !== want.last ||
            subtracted_o !== want.sub) begin
          bad_bins++;
          if (bad_bins <= REPORT_MAX)
            $display("result %0d: expected power %h last %b sub %b, got power %h last %b sub %b",
                     results_seen, want.power, want.last, want.sub,
                     power_out_o, frame_end_out_o, subtracted_o);
        end
        if (subtracted_o === 1'b1) results_subtracted++;
      end
    end
  end

  // Watchdog: covers the reset clearing pass and the worst stall patterns.
  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d results still pending",
               cycle_count, cleaned_due.size());
      $display("CHECK FAILED");
      $finish;
    end
  end

endmodule

// ===== filelist.f =====
+incdir+design
design/snr_pkg.sv
design/snr_ram.sv
design/snr_div.sv
design/snr_sub.sv
design/spectral_noise_subtract.sv
bench/spectral_noise_subtract_test.sv
